// ----- hdl/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared constants, the hue sector type and the sector helper functions.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int COMPONENT_BITS_DEF = 8;
    localparam int HUE_BITS           = 9;
    localparam int REM_BITS           = 6;
    localparam int FULL_TURN          = 360;
    localparam int SECTOR_DEG         = 60;

    typedef enum logic [2:0] {
        SECT_0 = 3'd0,
        SECT_1 = 3'd1,
        SECT_2 = 3'd2,
        SECT_3 = 3'd3,
        SECT_4 = 3'd4,
        SECT_5 = 3'd5
    } t_sector;

    function automatic t_sector hue_sector(input logic [HUE_BITS-1:0] hue);
        t_sector sec;
        if (hue < HUE_BITS'(SECTOR_DEG)) begin
            sec = SECT_0;
        end else if (hue < HUE_BITS'(2 * SECTOR_DEG)) begin
            sec = SECT_1;
        end else if (hue < HUE_BITS'(3 * SECTOR_DEG)) begin
            sec = SECT_2;
        end else if (hue < HUE_BITS'(4 * SECTOR_DEG)) begin
            sec = SECT_3;
        end else if (hue < HUE_BITS'(5 * SECTOR_DEG)) begin
            sec = SECT_4;
        end else begin
            sec = SECT_5;
        end
        return sec;
    endfunction

    function automatic logic [HUE_BITS-1:0] sector_base(input t_sector sec);
        logic [HUE_BITS-1:0] base;
        case (sec)
            SECT_0:  base = HUE_BITS'(0);
            SECT_1:  base = HUE_BITS'(SECTOR_DEG);
            SECT_2:  base = HUE_BITS'(2 * SECTOR_DEG);
            SECT_3:  base = HUE_BITS'(3 * SECTOR_DEG);
            SECT_4:  base = HUE_BITS'(4 * SECTOR_DEG);
            default: base = HUE_BITS'(5 * SECTOR_DEG);
        endcase
        return base;
    endfunction

endpackage

// ----- hdl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Streaming pixel color conversion from hue, saturation and value to RGB.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one pixel per request: hue in degrees (0..359,
//   larger codes wrap modulo 360), saturation and value with full scale
//   2^COMPONENT_BITS-1. Master channel returns red, green, blue.
//   Throughput is one pixel per cycle while the receiver does not stall;
//   each request passes through six register stages: sector split
//   and value*saturation, chroma estimate, chroma correction, chroma times
//   hue fraction, reciprocal multiply by 1/60, and correction with the
//   channel mapping into the output register.
//   The pipeline holds no state between pixels. Reset clears all valid
//   bits. When the receiver stalls with a result pending, every stage
//   freezes and o_s_axis_tready drops, so no request is lost or repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // hue, saturation, brightness, zero pad
    input  logic [((HUE_BITS+2*COMPONENT_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // red, green, blue, zero pad
    output logic [((3*COMPONENT_BITS+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int CB     = COMPONENT_BITS;
    localparam int OUT_W  = ((3*CB+7)/8)*8;
    localparam int P_W    = CB + REM_BITS;
    localparam int DIV_SH = CB + 8;
    localparam int MUL_W  = 2*CB + 9;
    localparam logic [CB-1:0]   MAXC  = '1;
    localparam logic [CB-1:0]   HALF  = MAXC >> 1;
    localparam logic [2*CB-1:0] MAX_1 = (2*CB)'(MAXC);
    localparam logic [2*CB-1:0] MAX_2 = MAX_1 << 1;
    localparam logic [CB+2:0]   RECIP = (CB+3)'((64'd1 << DIV_SH) / SECTOR_DEG);

    logic            w_adv;
    logic [5:0]      r_vld;

    logic [HUE_BITS-1:0] w_hue;
    logic [CB-1:0]       w_sat;
    logic [CB-1:0]       w_bri;
    logic [HUE_BITS-1:0] n1_hmod;
    t_sector             n1_sector;
    logic [HUE_BITS-1:0] n1_rem;

    t_sector             r1_sector;
    logic [REM_BITS-1:0] r1_rem;
    logic [2*CB-1:0]     r1_prod;
    logic [CB-1:0]       r1_bri;

    logic [2*CB-1:0]     n2_num;
    logic [2*CB:0]       n2_est;
    logic [REM_BITS-1:0] n2_frac;
    t_sector             r2_sector;
    logic [2*CB-1:0]     r2_num;
    logic [CB-1:0]       r2_q0;
    logic [REM_BITS-1:0] r2_frac;
    logic [CB-1:0]       r2_bri;

    logic [2*CB-1:0]     n3_qm;
    logic [2*CB-1:0]     n3_rem;
    logic [CB-1:0]       n3_c;
    t_sector             r3_sector;
    logic [CB-1:0]       r3_c;
    logic [REM_BITS-1:0] r3_frac;
    logic [CB-1:0]       r3_bri;

    t_sector             r4_sector;
    logic [P_W-1:0]      r4_p;
    logic [CB-1:0]       r4_c;
    logic [CB-1:0]       r4_m;

    logic [MUL_W-1:0]    n5_mul;
    t_sector             r5_sector;
    logic [P_W-1:0]      r5_p;
    logic [CB:0]         r5_qx;
    logic [CB-1:0]       r5_c;
    logic [CB-1:0]       r5_m;

    logic [P_W-1:0]      n6_rem;
    logic [CB-1:0]       n6_x;
    logic [CB-1:0]       n6_red;
    logic [CB-1:0]       n6_green;
    logic [CB-1:0]       n6_blue;
    logic [CB-1:0]       r_red;
    logic [CB-1:0]       r_green;
    logic [CB-1:0]       r_blue;

    assign w_adv           = !r_vld[5] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_vld[5];
    assign o_m_axis_tdata  = OUT_W'({r_blue, r_green, r_red});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[4:0], i_s_axis_tvalid};
        end
    end

    // stage 1: hue wrap, sector split, value times saturation
    assign w_hue     = i_s_axis_tdata[HUE_BITS-1:0];
    assign w_sat     = i_s_axis_tdata[HUE_BITS +: CB];
    assign w_bri     = i_s_axis_tdata[HUE_BITS+CB +: CB];
    assign n1_hmod   = (w_hue >= HUE_BITS'(FULL_TURN)) ? w_hue - HUE_BITS'(FULL_TURN) : w_hue;
    assign n1_sector = hue_sector(n1_hmod);
    assign n1_rem    = n1_hmod - sector_base(n1_sector);

    // stage 2: chroma estimate, floor((n + n>>CB) >> CB) is at most one low
    assign n2_num  = r1_prod + (2*CB)'(HALF);
    assign n2_est  = (2*CB+1)'(n2_num) + (2*CB+1)'(n2_num >> CB);
    assign n2_frac = r1_sector[0] ? REM_BITS'(SECTOR_DEG) - r1_rem : r1_rem;

    // stage 3: chroma correction
    assign n3_qm  = {r2_q0, CB'(0)} - (2*CB)'(r2_q0);
    assign n3_rem = r2_num - n3_qm;
    assign n3_c   = (n3_rem >= MAX_2) ? r2_q0 + CB'(2) :
                    (n3_rem >= MAX_1) ? r2_q0 + CB'(1) : r2_q0;

    // stage 5: multiply by reciprocal of 60
    assign n5_mul = MUL_W'(r4_p) * MUL_W'(RECIP);

    // stage 6: quotient correction
    assign n6_rem = r5_p - P_W'(P_W'(r5_qx) * P_W'(SECTOR_DEG));
    assign n6_x   = (n6_rem >= P_W'(SECTOR_DEG)) ? CB'(r5_qx + (CB+1)'(1)) : CB'(r5_qx);

    hsvrgb_sector_map #(
        .COMPONENT_BITS(CB)
    ) u_map (
        .i_sector (r5_sector),
        .i_chroma (r5_c),
        .i_inter  (n6_x),
        .i_offset (r5_m),
        .o_red    (n6_red),
        .o_green  (n6_green),
        .o_blue   (n6_blue)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_sector <= n1_sector;
            r1_rem    <= n1_rem[REM_BITS-1:0];
            r1_prod   <= (2*CB)'(w_bri) * (2*CB)'(w_sat);
            r1_bri    <= w_bri;

            r2_sector <= r1_sector;
            r2_num    <= n2_num;
            r2_q0     <= n2_est[2*CB-1:CB];
            r2_frac   <= n2_frac;
            r2_bri    <= r1_bri;

            r3_sector <= r2_sector;
            r3_c      <= n3_c;
            r3_frac   <= r2_frac;
            r3_bri    <= r2_bri;

            r4_sector <= r3_sector;
            r4_p      <= P_W'(r3_c) * P_W'(r3_frac) + P_W'(SECTOR_DEG / 2);
            r4_c      <= r3_c;
            r4_m      <= r3_bri - r3_c;

            r5_sector <= r4_sector;
            r5_p      <= r4_p;
            r5_qx     <= n5_mul[DIV_SH +: CB+1];
            r5_c      <= r4_c;
            r5_m      <= r4_m;

            r_red     <= n6_red;
            r_green   <= n6_green;
            r_blue    <= n6_blue;
        end
    end

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted pixel did not enter the pipeline");

    a_chroma_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (n3_rem < MAX_2 + MAX_1))
        else $error("chroma estimate off by more than two");

    a_chroma_le_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r3_c <= r3_bri))
        else $error("chroma exceeds value");

    a_inter_le_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (n6_x <= r5_c))
        else $error("intermediate component exceeds chroma");

endmodule

// ----- hdl/hsvrgb_sector_map.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB sector mapper
// Routes chroma, intermediate and zero to the three channels by hue sector
// and adds the common offset.
// ----------------------------------------------------------------------------
module hsvrgb_sector_map
    import hsvrgb_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  t_sector                   i_sector,
    input  logic [COMPONENT_BITS-1:0] i_chroma,
    input  logic [COMPONENT_BITS-1:0] i_inter,
    input  logic [COMPONENT_BITS-1:0] i_offset,
    output logic [COMPONENT_BITS-1:0] o_red,
    output logic [COMPONENT_BITS-1:0] o_green,
    output logic [COMPONENT_BITS-1:0] o_blue
);

    logic [COMPONENT_BITS-1:0] w_r;
    logic [COMPONENT_BITS-1:0] w_g;
    logic [COMPONENT_BITS-1:0] w_b;

    always_comb begin
        case (i_sector)
            SECT_0: begin
                w_r = i_chroma; w_g = i_inter;  w_b = '0;
            end
            SECT_1: begin
                w_r = i_inter;  w_g = i_chroma; w_b = '0;
            end
            SECT_2: begin
                w_r = '0;       w_g = i_chroma; w_b = i_inter;
            end
            SECT_3: begin
                w_r = '0;       w_g = i_inter;  w_b = i_chroma;
            end
            SECT_4: begin
                w_r = i_inter;  w_g = '0;       w_b = i_chroma;
            end
            default: begin
                w_r = i_chroma; w_g = '0;       w_b = i_inter;
            end
        endcase
    end

    assign o_red   = w_r + i_offset;
    assign o_green = w_g + i_offset;
    assign o_blue  = w_b + i_offset;

endmodule

// ----- tb/hsv_to_rgb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB checker
// Watches the slave and master channels of the converter. Every accepted
// request is turned into an expected red, green, blue triple by a fixed point
// model of the conversion. Every accepted result is compared field by field
// against the oldest expected triple. Mismatches, results with nothing
// pending, and the number of triples still pending are reported to the top.
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker
    import hsvrgb_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    input  logic i_s_axis_tready,
    // hue, saturation, brightness, zero pad
    input  logic [((HUE_BITS+2*COMPONENT_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic i_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // red, green, blue, zero pad
    input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] i_m_axis_tdata,
    output int   o_pending,
    output int   o_errors
);

    localparam int          CB         = COMPONENT_BITS;
    localparam int unsigned FULL_SCALE = (1 << CB) - 1;

    typedef struct packed {
        logic [CB-1:0] blue;
        logic [CB-1:0] green;
        logic [CB-1:0] red;
    } t_rgb;

    t_rgb  rgb_expected_q[$];
    int    err_count = 0;
    string chan_name[3] = '{"red", "green", "blue"};

    function automatic t_rgb hsv_to_rgb_expected(input logic [HUE_BITS-1:0] hue,
                                                 input logic [CB-1:0] sat,
                                                 input logic [CB-1:0] val);
        int unsigned deg, sect_idx, rem, vv, ss, chroma, frac, inter, offs;
        t_sector     sec;
        logic [CB-1:0] c_ch, x_ch, z_ch;
        t_rgb        pix;
        deg      = 32'(hue);
        deg      = deg % FULL_TURN;
        sect_idx = deg / SECTOR_DEG;
        sec      = t_sector'(sect_idx);
        rem      = deg % SECTOR_DEG;
        vv       = 32'(val);
        ss       = 32'(sat);
        chroma   = (vv * ss + FULL_SCALE / 2) / FULL_SCALE;
        frac     = (sect_idx % 2 == 1) ? SECTOR_DEG - rem : rem;
        inter    = (chroma * frac + SECTOR_DEG / 2) / SECTOR_DEG;
        offs     = vv - chroma;
        c_ch     = CB'(chroma + offs);
        x_ch     = CB'(inter + offs);
        z_ch     = CB'(offs);
        case (sec)
            SECT_0:  pix = '{blue: z_ch, green: x_ch, red: c_ch};
            SECT_1:  pix = '{blue: z_ch, green: c_ch, red: x_ch};
            SECT_2:  pix = '{blue: x_ch, green: c_ch, red: z_ch};
            SECT_3:  pix = '{blue: c_ch, green: x_ch, red: z_ch};
            SECT_4:  pix = '{blue: c_ch, green: z_ch, red: x_ch};
            default: pix = '{blue: x_ch, green: z_ch, red: c_ch};
        endcase
        return pix;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_rgb got;
        t_rgb want;
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata[3*CB-1:0];
                if (rgb_expected_q.size() == 0) begin
                    err_count++;
                    $display("%0t: result with no request pending, actual %h", $time, got);
                end else begin
                    want = rgb_expected_q.pop_front();
                    for (int k = 0; k < 3; k++) begin
                        if (got[k*CB +: CB] !== want[k*CB +: CB]) begin
                            err_count++;
                            $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                                     chan_name[k], want[k*CB +: CB], got[k*CB +: CB]);
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                rgb_expected_q.push_back(hsv_to_rgb_expected(
                    i_s_axis_tdata[HUE_BITS-1:0],
                    i_s_axis_tdata[HUE_BITS +: CB],
                    i_s_axis_tdata[HUE_BITS+CB +: CB]));
            end
        end
        o_pending <= rgb_expected_q.size();
        o_errors  <= err_count;
    end

endmodule

// ----- tb/hsv_to_rgb_converter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed corner pixels and then about 1550 random pixels into the
// converter in bursts with random gaps, while the receiver stalls in changing
// patterns and twice holds off long enough to back up the pipeline. The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;

    import hsvrgb_pkg::*;

    localparam int CB           = COMPONENT_BITS_DEF;
    localparam int IN_W         = ((HUE_BITS + 2 * CB + 7) / 8) * 8;
    localparam int OUT_W        = ((3 * CB + 7) / 8) * 8;
    localparam int MAXC         = (1 << CB) - 1;
    localparam int MAX_HUE      = (1 << HUE_BITS) - 1;
    localparam int RANDOM_ITEMS = 1550;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 16;
    localparam int HOLD_CYCLES  = 250;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    logic            i_clk           = 1'b0;
    logic            i_rst_n         = 1'b0;
    logic            s_axis_tvalid   = 1'b0;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata    = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready   = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    int              pending;
    int              errors;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    hsv_to_rgb_converter #(
        .COMPONENT_BITS (CB)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata)
    );

    hsv_to_rgb_checker #(
        .COMPONENT_BITS (CB)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_pending       (pending),
        .o_errors        (errors)
    );

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // receiver: stall pattern changes at random intervals
    initial begin : receiver
        int unsigned cyc;
        int unsigned hold;
        int unsigned mode_left;
        t_rx_mode    mode;
        cyc       = 0;
        hold      = 0;
        mode_left = 0;
        mode      = RX_ALWAYS;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 600 || cyc == 2200) begin
                hold = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(RX_ALWAYS, RX_SPARSE));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_ALWAYS:   m_axis_tready <= 1'b1;
                    RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_axis_tready <= (cyc % 4) != 0;
                    default:     m_axis_tready <= $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    task automatic send_pixel(input int hue, input int sat, input int val);
        s_axis_tdata  <= IN_W'({val[CB-1:0], sat[CB-1:0], hue[HUE_BITS-1:0]});
        s_axis_tvalid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // drop valid and hold until every expected result has arrived
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending != 0) begin
            $display("Mismatches found");
            $finish;
        end
    endtask

    function automatic int pick_component();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            return 0;
        end else if (sel == 1) begin
            return MAXC;
        end
        return $urandom_range(0, MAXC);
    endfunction

    initial begin : stimulus
        int sent;
        int burst;
        int gap;
        int hue;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        for (int k = 0; k < 6; k++) begin
            send_pixel(k * SECTOR_DEG, MAXC, MAXC);
            send_pixel(k * SECTOR_DEG + SECTOR_DEG - 1, MAXC, MAXC);
        end
        send_pixel(FULL_TURN, MAXC, MAXC);
        send_pixel(MAX_HUE, MAXC, MAXC);
        send_pixel(FULL_TURN + 59, 200, 180);
        send_pixel(90, 0, 200);
        send_pixel(200, MAXC, 0);
        send_pixel(30, 0, 0);
        send_pixel(150, MAXC, 1);
        send_pixel(270, 1, MAXC);
        send_pixel(30, 128, 128);
        send_pixel(330, 127, 254);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 48);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    hue = $urandom_range(FULL_TURN, MAX_HUE);
                end else begin
                    hue = $urandom_range(0, FULL_TURN - 1);
                end
                send_pixel(hue, pick_component(), pick_component());
                sent++;
                if (sent == RANDOM_ITEMS / 2) begin
                    wait_drained();
                end
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
